// ===== hdl/gamepad_to_midi_cc_converter_core_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the gamepad to midi cc converter
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_TO_MIDI_CC_CONVERTER_CORE_MACROS_SVH
`define GAMEPAD_TO_MIDI_CC_CONVERTER_CORE_MACROS_SVH

// checked only while out of reset
`define G2M_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define G2M_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/g2mcc_pkg.sv =====
// ----------------------------------------------------------------------------
// g2mcc_pkg
// types and constants shared by the gamepad to midi cc converter
// ----------------------------------------------------------------------------
`default_nettype none

package g2mcc_pkg;

  localparam int NumControls = 22;
  localparam int QDepth      = 2;
  localparam int QPtrW       = 1;
  localparam int QCntW       = 2;

  localparam logic [7:0] TurntableReset = 8'd23;
  localparam logic [6:0] ValMax         = 7'd127;
  localparam logic [4:0] CtlFirstStick  = 5'd2;
  localparam logic [4:0] CtlFirstButton = 5'd6;

  typedef logic [NumControls-1:0] ctl_mask_t;

  // one gamepad snapshot
  typedef struct packed {
    logic        [1:0]  pad_index;
    logic        [7:0]  left_trigger;
    logic        [7:0]  right_trigger;
    logic signed [15:0] left_stick_x;
    logic signed [15:0] left_stick_y;
    logic signed [15:0] right_stick_x;
    logic signed [15:0] right_stick_y;
    logic        [15:0] button_bits;
    logic        [7:0]  device_subtype;
  } snap_t;

  // one control-change message
  typedef struct packed {
    logic [1:0] channel;
    logic [4:0] control_number;
    logic [6:0] control_value;
    logic       last_of_run;
  } msg_t;

  // classified snapshot waiting for the back end
  typedef struct packed {
    logic [1:0]      channel;
    ctl_mask_t       change_mask;
    logic [1:0][6:0] trig_val;
    logic [3:0][6:0] stick_val;
    logic [15:0]     button_bits;
  } job_t;

  // queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== hdl/g2mcc_front.sv =====
// ----------------------------------------------------------------------------
// g2mcc_front
// compares a snapshot with the stored one of its pad, scales all values and
// builds the change mask
// ----------------------------------------------------------------------------
`default_nettype none

module g2mcc_front #(
  parameter int NUM_PADS = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  input  wire logic [7:0]       cfg_data_i,
  input  wire logic             accept_i,
  input  wire g2mcc_pkg::snap_t snap_i,
  output logic                  job_push_o,
  output g2mcc_pkg::job_t       job_o
);

  localparam int PadW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

  function automatic logic [6:0] scale_trig(input logic [7:0] v);
    logic [14:0] prod;
    logic [15:0] t;
    prod = 15'(v) * 15'd127;
    // divide by 255, exact below 65535
    t = 16'(prod) + 16'(prod >> 8) + 16'd1;
    return t[14:8];
  endfunction

  function automatic logic [6:0] scale_stick(input logic signed [15:0] v);
    return {~v[15], v[14:9]};
  endfunction

  function automatic logic [6:0] deck_off(input logic signed [15:0] v);
    logic [6:0] r;
    if (v < -16'sd64) begin
      r = '0;
    end else if (v > 16'sd63) begin
      r = g2mcc_pkg::ValMax;
    end else begin
      r = {~v[6], v[5:0]};
    end
    return r;
  endfunction

  logic [7:0]  turntable_q;
  logic [15:0] trig_q  [NUM_PADS];
  logic [63:0] stick_q [NUM_PADS];
  logic [15:0] btn_q   [NUM_PADS];

  logic                 pad_ok;
  logic [PadW-1:0]      idx;
  logic [15:0]          old_trig;
  logic [63:0]          old_stick;
  logic [15:0]          old_btn;
  logic [15:0]          new_trig;
  logic [63:0]          new_stick;
  logic                 deck;
  g2mcc_pkg::ctl_mask_t mask;

  assign pad_ok    = int'(snap_i.pad_index) < NUM_PADS;
  assign idx       = PadW'(snap_i.pad_index);
  assign old_trig  = trig_q[idx];
  assign old_stick = stick_q[idx];
  assign old_btn   = btn_q[idx];
  assign new_trig  = {snap_i.right_trigger, snap_i.left_trigger};
  assign new_stick = {snap_i.right_stick_y, snap_i.right_stick_x,
                      snap_i.left_stick_y, snap_i.left_stick_x};
  assign deck      = snap_i.device_subtype == turntable_q;

  // change mask in control order
  assign mask[0]    = new_trig[7:0]    != old_trig[7:0];
  assign mask[1]    = new_trig[15:8]   != old_trig[15:8];
  assign mask[2]    = new_stick[15:0]  != old_stick[15:0];
  assign mask[3]    = new_stick[31:16] != old_stick[31:16];
  assign mask[4]    = new_stick[47:32] != old_stick[47:32];
  assign mask[5]    = new_stick[63:48] != old_stick[63:48];
  assign mask[21:6] = snap_i.button_bits ^ old_btn;

  // job payload
  always_comb begin
    job_o.channel      = snap_i.pad_index;
    job_o.change_mask  = mask;
    job_o.trig_val[0]  = scale_trig(snap_i.left_trigger);
    job_o.trig_val[1]  = scale_trig(snap_i.right_trigger);
    job_o.stick_val[0] = deck ? deck_off(snap_i.left_stick_x)
                              : scale_stick(snap_i.left_stick_x);
    job_o.stick_val[1] = deck ? deck_off(snap_i.left_stick_y)
                              : scale_stick(snap_i.left_stick_y);
    job_o.stick_val[2] = scale_stick(snap_i.right_stick_x);
    job_o.stick_val[3] = scale_stick(snap_i.right_stick_y);
    job_o.button_bits  = snap_i.button_bits;
  end

  assign job_push_o = accept_i && pad_ok && (|mask);

  // turntable subtype register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turntable_q <= g2mcc_pkg::TurntableReset;
    end else if (cfg_valid_i) begin
      turntable_q <= cfg_data_i;
    end
  end

  // last snapshot per pad
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PADS; p++) begin
        trig_q[p]  <= '0;
        stick_q[p] <= '0;
        btn_q[p]   <= '0;
      end
    end else if (accept_i && pad_ok) begin
      trig_q[idx]  <= new_trig;
      stick_q[idx] <= new_stick;
      btn_q[idx]   <= snap_i.button_bits;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/g2mcc_queue.sv =====
// ----------------------------------------------------------------------------
// g2mcc_queue
// short job queue between the front and back ends
// ----------------------------------------------------------------------------
`default_nettype none

module g2mcc_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_en_i,
  input  wire g2mcc_pkg::job_t wr_data_i,
  input  wire logic            rd_en_i,
  output g2mcc_pkg::job_t      rd_data_o,
  output g2mcc_pkg::q_stat_t   stat_o
);

  g2mcc_pkg::job_t               mem_q [g2mcc_pkg::QDepth];
  logic [g2mcc_pkg::QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [g2mcc_pkg::QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [g2mcc_pkg::QCntW-1:0]   cnt_q, cnt_d;

  assign stat_o.full  = cnt_q == g2mcc_pkg::QCntW'(g2mcc_pkg::QDepth);
  assign stat_o.empty = cnt_q == '0;
  assign rd_data_o    = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en_i && !wr_en_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/g2mcc_back.sv =====
// ----------------------------------------------------------------------------
// g2mcc_back
// walks the change mask of one job and issues one message per cycle into
// the output register whenever that register is empty or being popped
// ----------------------------------------------------------------------------
`default_nettype none

module g2mcc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire g2mcc_pkg::job_t    job_i,
  input  wire g2mcc_pkg::q_stat_t q_stat_i,
  output logic                    q_pop_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output g2mcc_pkg::msg_t         out_o
);

  g2mcc_pkg::job_t      job_q, job_d;
  logic                 job_vld_q, job_vld_d;
  g2mcc_pkg::msg_t      out_q, out_d;
  logic                 out_vld_q, out_vld_d;

  logic                 out_free;
  logic                 issue;
  logic                 last;
  logic                 load;
  logic [4:0]           sel;
  g2mcc_pkg::ctl_mask_t rem;
  logic [6:0]           val;

  assign out_free = !out_vld_q || pop_i;
  assign issue    = job_vld_q && out_free;

  // lowest pending control
  always_comb begin
    sel = '0;
    for (int k = g2mcc_pkg::NumControls - 1; k >= 0; k--) begin
      if (job_q.change_mask[k]) begin
        sel = 5'(k);
      end
    end
  end

  assign rem  = job_q.change_mask & ~(g2mcc_pkg::ctl_mask_t'(1) << sel);
  assign last = rem == '0;
  assign load = !q_stat_i.empty && (!job_vld_q || (issue && last));
  assign q_pop_o = load;

  // value of the selected control
  always_comb begin
    logic [4:0] sidx;
    logic [4:0] bidx;
    sidx = sel - g2mcc_pkg::CtlFirstStick;
    bidx = sel - g2mcc_pkg::CtlFirstButton;
    if (sel < g2mcc_pkg::CtlFirstStick) begin
      val = job_q.trig_val[sel[0]];
    end else if (sel < g2mcc_pkg::CtlFirstButton) begin
      val = job_q.stick_val[sidx[1:0]];
    end else begin
      val = job_q.button_bits[bidx[3:0]] ? g2mcc_pkg::ValMax : '0;
    end
  end

  // job register
  always_comb begin
    job_d     = job_q;
    job_vld_d = job_vld_q;
    if (load) begin
      job_d     = job_i;
      job_vld_d = 1'b1;
    end else if (issue) begin
      job_d.change_mask = rem;
      job_vld_d         = !last;
    end
  end

  // output register
  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q;
    if (issue) begin
      out_d.channel        = job_q.channel;
      out_d.control_number = sel;
      out_d.control_value  = val;
      out_d.last_of_run    = last;
      out_vld_d            = 1'b1;
    end else if (pop_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      job_vld_q <= job_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  assign empty_o = !out_vld_q;
  assign out_o   = out_q;

endmodule

`default_nettype wire

// ===== hdl/gamepad_to_midi_cc_converter_core.sv =====
// path: an accepted snapshot goes into the job queue, then the job register;
// then one message per changed control (0 to 22) enters the output register
// throughput: one snapshot per cycle enters while the two-entry job queue has
// room; the back end walker gives one message/cycle while the receiver pops
// reset: asynchronous, clears all stored pad snapshots at once, empties the
// queue and sets the turntable subtype to 23; no clearing pass
// ----------------------------------------------------------------------------
// gamepad_to_midi_cc_converter_core
// turns gamepad snapshots into midi control-change messages for the fields
// that changed since the pad's last snapshot
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_to_midi_cc_converter_core #(
  parameter int NUM_PADS = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [7:0]       cfg_data_i,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire g2mcc_pkg::snap_t in_i,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output g2mcc_pkg::msg_t       out_o
);

  g2mcc_pkg::job_t    job_wr;
  g2mcc_pkg::job_t    job_rd;
  g2mcc_pkg::q_stat_t q_stat;
  logic               job_push;
  logic               job_pop;
  logic               accept;

  assign cfg_ready_o = 1'b1;
  assign full_o      = q_stat.full;
  assign accept      = push_i && !q_stat.full;

  // classify snapshots
  g2mcc_front #(
    .NUM_PADS(NUM_PADS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .snap_i     (in_i),
    .job_push_o (job_push),
    .job_o      (job_wr)
  );

  // decouple front from back
  g2mcc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (job_push),
    .wr_data_i(job_wr),
    .rd_en_i  (job_pop),
    .rd_data_o(job_rd),
    .stat_o   (q_stat)
  );

  // issue messages
  g2mcc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (job_rd),
    .q_stat_i(q_stat),
    .q_pop_o (job_pop),
    .pop_i   (pop_i),
    .empty_o (empty_o),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ===== hdl/g2mcc_checker.sv =====
// ----------------------------------------------------------------------------
// g2mcc_checker
// port-level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "gamepad_to_midi_cc_converter_core_macros.svh"

module g2mcc_checker #(
  parameter int NUM_PADS = 4
) (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            empty_o,
  input wire logic            pop_i,
  input wire g2mcc_pkg::msg_t out_o
);

  logic chan_ok;
  logic ctl_ok;
  logic is_button;
  logic on_off;

  // field checks on the shown result
  assign chan_ok   = int'(out_o.channel) < NUM_PADS;
  assign ctl_ok    = int'(out_o.control_number) < g2mcc_pkg::NumControls;
  assign is_button = out_o.control_number >= g2mcc_pkg::CtlFirstButton;
  assign on_off    = (out_o.control_value == g2mcc_pkg::ValMax) ||
                     (out_o.control_value == '0);

  // nothing to deliver while in reset
  `G2M_ASSERT_ALWAYS(a_empty_in_reset, !rst_ni |-> empty_o, "result shown during reset")

  // a waiting result holds until taken
  `G2M_ASSERT(a_hold, !empty_o && !pop_i |=> !empty_o && $stable(out_o), "result dropped")

  // channel names an existing pad
  `G2M_ASSERT(a_channel, !empty_o |-> chan_ok, "bad channel")

  // only 22 controls exist
  `G2M_ASSERT(a_ctl_range, !empty_o |-> ctl_ok, "bad control")

  // buttons send full on or off
  `G2M_ASSERT(a_button_val, !empty_o && is_button |-> on_off, "bad button value")

endmodule

bind gamepad_to_midi_cc_converter_core g2mcc_checker #(
  .NUM_PADS(NUM_PADS)
) u_g2mcc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .empty_o(empty_o),
  .pop_i  (pop_i),
  .out_o  (out_o)
);

`default_nettype wire

// ===== sim/gamepad_to_midi_cc_converter_core_test.sv =====
// ----------------------------------------------------------------------------
// gamepad_to_midi_cc_converter_core_test
// self-checking bench: pushes gamepad snapshots, predicts the control-change
// messages per pad from its own copy of the last snapshots, and checks every
// popped message field by field across idling phases and turntable settings
// ----------------------------------------------------------------------------

module gamepad_to_midi_cc_converter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         NumPads         = 4;
  localparam logic [4:0] CtlFirstTrigger = 5'd0;
  localparam int         PhaseItems      = 118;
  localparam int         HoldCycles      = 200;

  // predicts the message stream and checks popped messages against it
  class midi_cc_scoreboard;
    logic [7:0]       trig_mem  [NumPads][2];
    logic [15:0]      stick_mem [NumPads][4];
    logic [15:0]      btn_mem   [NumPads];
    logic [7:0]       turntable;
    g2mcc_pkg::msg_t  expected [$];
    int               failures;
    int               checked;
    int               snapshots;

    function new();
      for (int p = 0; p < NumPads; p++) begin
        trig_mem[p][0] = '0;
        trig_mem[p][1] = '0;
        for (int k = 0; k < 4; k++) stick_mem[p][k] = '0;
        btn_mem[p] = '0;
      end
      turntable = g2mcc_pkg::TurntableReset;
      failures  = 0;
      checked   = 0;
      snapshots = 0;
    endfunction

    function void set_turntable(logic [7:0] v);
      turntable = v;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void add_msg(int pad, logic [4:0] ctl, int val);
      g2mcc_pkg::msg_t m;
      m.channel        = pad[1:0];
      m.control_number = ctl;
      m.control_value  = val[6:0];
      m.last_of_run    = 1'b0;
      expected.push_back(m);
    endfunction

    // accepted snapshot: queue one message per changed control
    function void note_snapshot(g2mcc_pkg::snap_t s);
      logic [7:0]  trig [2];
      logic [15:0] stk  [4];
      bit          deck;
      int          pad, n0, v;
      pad  = s.pad_index;
      n0   = expected.size();
      deck = (s.device_subtype == turntable);
      trig[0] = s.left_trigger;
      trig[1] = s.right_trigger;
      stk[0]  = s.left_stick_x;
      stk[1]  = s.left_stick_y;
      stk[2]  = s.right_stick_x;
      stk[3]  = s.right_stick_y;
      snapshots++;
      if (pad >= NumPads) return;
      for (int k = 0; k < 2; k++) begin
        if (trig[k] != trig_mem[pad][k])
          add_msg(pad, CtlFirstTrigger + 5'(k), 127 * int'(trig[k]) / 255);
        trig_mem[pad][k] = trig[k];
      end
      for (int k = 0; k < 4; k++) begin
        if (stk[k] != stick_mem[pad][k]) begin
          if (deck && k < 2) begin
            // deck offset, clamped to the midi range
            v = int'($signed(stk[k])) + 64;
            if (v < 0) v = 0;
            if (v > 127) v = 127;
          end else begin
            v = (int'($signed(stk[k])) + 32768) / 512;
          end
          add_msg(pad, g2mcc_pkg::CtlFirstStick + 5'(k), v);
        end
        stick_mem[pad][k] = stk[k];
      end
      for (int k = 0; k < 16; k++) begin
        if (s.button_bits[k] != btn_mem[pad][k])
          add_msg(pad, g2mcc_pkg::CtlFirstButton + 5'(k),
                  s.button_bits[k] ? int'(g2mcc_pkg::ValMax) : 0);
      end
      btn_mem[pad] = s.button_bits;
      if (expected.size() > n0) expected[expected.size()-1].last_of_run = 1'b1;
    endfunction

    function void compare_field(string name, logic [6:0] e, logic [6:0] a);
      if (a !== e) begin
        failures++;
        $display("%0t: %s expected %0d got %0d", $time, name, e, a);
      end
    endfunction

    // popped message against the oldest prediction
    function void check_message(g2mcc_pkg::msg_t m);
      g2mcc_pkg::msg_t e;
      checked++;
      if (expected.size() == 0) begin
        failures++;
        $display("%0t: expected no message, got ch %0d ctl %0d val %0d", $time,
                 m.channel, m.control_number, m.control_value);
        return;
      end
      e = expected.pop_front();
      compare_field("channel", 7'(e.channel), 7'(m.channel));
      compare_field("control_number", 7'(e.control_number), 7'(m.control_number));
      compare_field("control_value", e.control_value, m.control_value);
      compare_field("last_of_run", 7'(e.last_of_run), 7'(m.last_of_run));
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni;
  logic             cfg_valid_r = 1'b0;
  logic [7:0]       cfg_data_r  = '0;
  logic             push_r      = 1'b0;
  g2mcc_pkg::snap_t in_r        = '0;
  logic             pop_r       = 1'b0;
  logic             cfg_ready_o;
  logic             full_o;
  logic             empty_o;
  g2mcc_pkg::msg_t  out_o;

  midi_cc_scoreboard sb = new();

  int               sender_idle_pct    = 0;
  int               receiver_stall_pct = 0;
  int               hold_tickets       = 0;
  int               hold_seen          = 0;
  int               hold_left          = 0;
  int               full_stalls        = 0;
  logic [7:0]       turntable_now      = g2mcc_pkg::TurntableReset;
  g2mcc_pkg::snap_t last_sent [NumPads];

  gamepad_to_midi_cc_converter_core #(
    .NUM_PADS(NumPads)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_r),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_r),
    .push_i     (push_r),
    .full_o     (full_o),
    .in_i       (in_r),
    .empty_o    (empty_o),
    .pop_i      (pop_r),
    .out_o      (out_o)
  );

  always #10 clk_i = ~clk_i;

  // watch both queue ends at every edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push_r && !full_o) sb.note_snapshot(in_r);
      if (push_r && full_o) full_stalls++;
      if (pop_r && !empty_o) sb.check_message(out_o);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop_r <= 1'b0;
    end else if (hold_seen != hold_tickets) begin
      hold_seen = hold_tickets;
      hold_left = HoldCycles;
      pop_r <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop_r <= 1'b0;
    end else begin
      pop_r <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("run limit reached with %0d messages still expected", sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic g2mcc_pkg::snap_t mk_snap(logic [1:0] pad, logic [7:0] lt,
                                               logic [7:0] rt, logic [15:0] lx,
                                               logic [15:0] ly, logic [15:0] rx,
                                               logic [15:0] ry, logic [15:0] btn,
                                               logic [7:0] sub);
    g2mcc_pkg::snap_t s;
    s.pad_index      = pad;
    s.left_trigger   = lt;
    s.right_trigger  = rt;
    s.left_stick_x   = lx;
    s.left_stick_y   = ly;
    s.right_stick_x  = rx;
    s.right_stick_y  = ry;
    s.button_bits    = btn;
    s.device_subtype = sub;
    return s;
  endfunction

  // random snapshot, mostly small edits of the pad's previous one
  function automatic g2mcc_pkg::snap_t next_snapshot();
    g2mcc_pkg::snap_t s;
    logic [127:0]     r;
    int               pad, pick;
    pad  = $urandom_range(NumPads - 1);
    s    = last_sent[pad];
    pick = $urandom_range(99);
    if (pick < 40) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(5))
          0: s.left_trigger = 8'($urandom);
          1: s.right_trigger = 8'($urandom);
          2: s.right_stick_x = 16'($urandom);
          3: s.right_stick_y = s.right_stick_y + 16'($urandom_range(1023)) - 16'd512;
          4: s.button_bits[$urandom_range(15)] ^= 1'b1;
          default: s.left_stick_y = 16'($urandom);
        endcase
      end
    end else if (pick < 50) begin
      // resend unchanged
    end else if (pick < 60) begin
      s.device_subtype = 8'($urandom);
    end else if (pick < 80) begin
      r = {$urandom, $urandom, $urandom, $urandom};
      s = r[$bits(g2mcc_pkg::snap_t)-1:0];
    end else begin
      // turntable snapshot, deck offsets around and past the clamp points
      s.device_subtype = turntable_now;
      s.left_stick_x   = 16'($urandom_range(200)) - 16'd100;
      s.left_stick_y   = 16'($urandom_range(200)) - 16'd100;
      if ($urandom_range(3) == 0) s.left_stick_x = 16'($urandom);
      if ($urandom_range(3) == 0) s.button_bits = 16'($urandom);
    end
    s.pad_index = 2'(pad);
    last_sent[pad] = s;
    return s;
  endfunction

  task automatic send_snapshot(input g2mcc_pkg::snap_t s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      push_r <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_r   <= s;
    push_r <= 1'b1;
    do @(posedge clk_i); while (full_o);
  endtask

  // let the pending push be sampled first so the last accepted snapshot is already predicted
  task automatic wait_drained();
    push_r <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // register write only once the block has gone quiet
  task automatic write_turntable(input logic [7:0] v);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_data_r  <= v;
    cfg_valid_r <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_r <= 1'b0;
    sb.set_turntable(v);
    turntable_now = v;
  endtask

  initial begin
    logic [7:0] settings [4];
    int         idle_plan  [4];
    int         stall_plan [4];
    rst_ni <= 1'b0;
    for (int p = 0; p < NumPads; p++) last_sent[p] = '0;
    settings   = '{8'd0, 8'd255, 8'($urandom), g2mcc_pkg::TurntableReset};
    idle_plan  = '{0, 71, 0, 10};
    stall_plan = '{0, 0, 71, 10};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, deck clamps, subtype-only and unchanged snapshots
    send_snapshot(mk_snap(2'd0, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                          16'h0000, 8'd0));
    send_snapshot(mk_snap(2'd0, 8'd255, 8'd255, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                          16'hffff, 8'd0));
    send_snapshot(mk_snap(2'd0, 8'd255, 8'd255, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                          16'hffff, 8'd0));
    send_snapshot(mk_snap(2'd0, 8'd255, 8'd255, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                          16'hffff, 8'd23));
    send_snapshot(mk_snap(2'd0, 8'd255, 8'd255, -16'sd65, 16'sd64, 16'h8000, 16'h7fff,
                          16'hffff, 8'd23));
    send_snapshot(mk_snap(2'd0, 8'd1, 8'd2, -16'sd64, 16'sd63, 16'h8000, 16'h7fff,
                          16'hffff, 8'd23));
    send_snapshot(mk_snap(2'd1, 8'd128, 8'd254, 16'hffff, 16'h0001, -16'sd512, 16'sd511,
                          16'h5555, 8'd22));
    send_snapshot(mk_snap(2'd2, 8'd0, 8'd0, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
                          16'haaaa, 8'd255));
    send_snapshot(mk_snap(2'd3, 8'd0, 8'd0, 16'h7fff, 16'h8000, 16'h0000, 16'h0000,
                          16'h8001, 8'd23));
    send_snapshot(mk_snap(2'd1, 8'd128, 8'd254, 16'hffff, 16'h0001, -16'sd512, 16'sd511,
                          16'haaaa, 8'd22));
    send_snapshot(mk_snap(2'd0, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                          16'h0000, 8'd0));
    send_snapshot(mk_snap(2'd3, 8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                          16'h0000, 8'd23));
    last_sent[1] = mk_snap(2'd1, 8'd128, 8'd254, 16'hffff, 16'h0001, -16'sd512, 16'sd511,
                           16'haaaa, 8'd22);
    last_sent[2] = mk_snap(2'd2, 8'd0, 8'd0, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
                           16'haaaa, 8'd255);

    // random phases, one idling pattern and one turntable setting each
    for (int ph = 0; ph < 4; ph++) begin
      write_turntable(settings[ph]);
      sender_idle_pct    = idle_plan[ph];
      receiver_stall_pct = stall_plan[ph];
      for (int i = 0; i < PhaseItems; i++) begin
        if (ph == 0 && i == 40) hold_tickets++;
        if (ph == 2 && i == 60) wait_drained();
        send_snapshot(next_snapshot());
      end
    end

    wait_drained();
    receiver_stall_pct = 0;
    repeat (12) @(posedge clk_i);

    $display("covered %0d snapshots and %0d messages, four idling phases, four subtype",
             sb.snapshots, sb.checked);
    $display("settings, input held off on %0d edges", full_stalls);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== gamepad_to_midi_cc_converter_core.f =====
+incdir+hdl
hdl/g2mcc_pkg.sv
hdl/g2mcc_front.sv
hdl/g2mcc_queue.sv
hdl/g2mcc_back.sv
hdl/gamepad_to_midi_cc_converter_core.sv
hdl/g2mcc_checker.sv
sim/gamepad_to_midi_cc_converter_core_test.sv
